/* design/sosl_pkg.sv */
// Shared types and constants of the self-organizing symbol list.
package sosl_pkg;

  localparam int SYM_W = 8;
  localparam int CNT_W = 9;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] UPD_NONE   = 2'd0;
  localparam logic [1:0] UPD_MTF    = 2'd1;
  localparam logic [1:0] UPD_SWAP   = 2'd2;
  localparam logic [1:0] UPD_APPEND = 2'd3;

  typedef struct packed {
    logic             en;
    logic             access;
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] ridx;
    logic [CNT_W-1:0] count;
  } sosl_cmp_t;

  typedef struct packed {
    logic             en;
    logic [1:0]       kind;
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] found;
    logic [CNT_W-1:0] count;
  } sosl_upd_t;

endpackage

/* design/self_organizing_symbol_list.sv */
// Self-organizing symbol list top level: a row of cells with a three-step sequencer.
// Each request goes through three steps from acceptance to its result in the output register:
// compare in all cells, encode the match row, then reorder the cells and update the total.
// A new request is taken while idle, or in an update step that the output stall does not hold.
// Reset empties the list, clears the total and sets move-to-front mode; symbol cells are
// not cleared, since only entries below the list length are ever read.
module self_organizing_symbol_list #(
  parameter int LIST_DEPTH  = 256,
  parameter int TOTAL_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  symbol_i,
  input  logic [7:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [8:0]  position_o,
  output logic [31:0] comparison_total_o,
  output logic [8:0]  list_length_o,
  output logic [7:0]  entry_symbol_o,
  output logic        entry_valid_o,
  output logic        list_full_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        reorder_mode_i
);

  localparam int CW = sosl_pkg::CNT_W;
  localparam int SW = sosl_pkg::SYM_W;
  localparam logic [CW-1:0] DepthVal = CW'(LIST_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_ENC  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       mode_q;

  logic [1:0]    op_q;
  logic [SW-1:0] sym_q;
  logic [CW-1:0] ridx_q;

  logic [CW-1:0]          count_q, count_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;

  logic [CW-1:0] found_q;
  logic          hit_q;
  logic [SW-1:0] esym_q;

  logic          out_valid_q;
  logic          hit_out_q;
  logic [CW-1:0] pos_out_q;
  logic [31:0]   total_out_q;
  logic [CW-1:0] len_out_q;
  logic [SW-1:0] esym_out_q;
  logic          evalid_out_q;
  logic          full_out_q;

  logic in_fire, out_free, upd_fire;

  sosl_pkg::sosl_cmp_t cmp;
  sosl_pkg::sosl_upd_t upd;

  logic [LIST_DEPTH-1:0]         match;
  logic [LIST_DEPTH-1:0][SW-1:0] cell_sym;
  logic [CW-1:0]                 enc_found;
  logic                          enc_any;
  logic [SW-1:0]                 enc_sym;

  logic                   is_access, is_read, is_clear;
  logic [CW-1:0]          amount;
  logic [TOTAL_WIDTH:0]   sum;
  logic [TOTAL_WIDTH-1:0] added;
  logic [63:0]            total_ext;
  logic [31:0]            total_rep;
  logic [CW-1:0]          pos_d;
  logic                   full_d;
  logic                   evalid_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign upd_fire   = (state_q == ST_UPD) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || upd_fire);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign is_access = op_q == sosl_pkg::OP_ACCESS;
  assign is_read   = op_q == sosl_pkg::OP_READ;
  assign is_clear  = op_q == sosl_pkg::OP_CLEAR;

  always_comb begin
    cmp.en     = state_q == ST_CMP;
    cmp.access = is_access;
    cmp.sym    = sym_q;
    cmp.ridx   = ridx_q;
    cmp.count  = count_q;
  end

  always_comb begin
    upd.en    = upd_fire && is_access;
    upd.sym   = sym_q;
    upd.found = found_q;
    upd.count = count_q;
    upd.kind  = sosl_pkg::UPD_NONE;
    if (hit_q) begin
      if (found_q != '0) begin
        upd.kind = mode_q ? sosl_pkg::UPD_SWAP : sosl_pkg::UPD_MTF;
      end
    end else if (count_q < DepthVal) begin
      upd.kind = sosl_pkg::UPD_APPEND;
    end
  end

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [SW-1:0] left_sym;
    if (k == 0) begin : g_head
      assign left_sym = '0;
    end else begin : g_link
      assign left_sym = cell_sym[k-1];
    end
    sosl_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmp_i      (cmp),
      .upd_i      (upd),
      .left_sym_i (left_sym),
      .sym_o      (cell_sym[k]),
      .match_o    (match[k])
    );
  end

  sosl_enc #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_enc (
    .match_i (match),
    .syms_i  (cell_sym),
    .found_o (enc_found),
    .any_o   (enc_any),
    .sym_o   (enc_sym)
  );

  always_comb begin
    pos_d    = hit_q ? found_q + 1'b1 : '0;
    amount   = hit_q ? pos_d : count_q;
    sum      = {1'b0, total_q} + (TOTAL_WIDTH + 1)'(amount);
    added    = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
    full_d   = !hit_q && (count_q == DepthVal);
    evalid_d = ridx_q < count_q;
    total_d  = total_q;
    count_d  = count_q;
    if (is_access) begin
      total_d = added;
      if (!hit_q && !full_d) begin
        count_d = count_q + 1'b1;
      end
    end else if (is_clear) begin
      total_d = '0;
      count_d = '0;
    end
    total_ext = 64'(total_d);
    total_rep = (|total_ext[63:32]) ? '1 : total_ext[31:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP:  state_d = ST_ENC;
      ST_ENC:  state_d = ST_UPD;
      ST_UPD: begin
        if (upd_fire) begin
          state_d = in_fire ? ST_CMP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= reorder_mode_i;
      end
      if (upd_fire) begin
        count_q     <= count_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= operation_i;
      sym_q  <= symbol_i;
      ridx_q <= CW'(read_index_i);
    end
    if (state_q == ST_ENC) begin
      found_q <= enc_found;
      hit_q   <= enc_any;
      esym_q  <= enc_sym;
    end
    if (upd_fire) begin
      hit_out_q    <= is_access && hit_q;
      pos_out_q    <= is_access ? pos_d : '0;
      total_out_q  <= total_rep;
      len_out_q    <= count_d;
      evalid_out_q <= is_read && evalid_d;
      esym_out_q   <= (is_read && evalid_d) ? esym_q : '0;
      full_out_q   <= is_access && full_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = hit_out_q;
  assign position_o         = pos_out_q;
  assign comparison_total_o = total_out_q;
  assign list_length_o      = len_out_q;
  assign entry_symbol_o     = esym_out_q;
  assign entry_valid_o      = evalid_out_q;
  assign list_full_o        = full_out_q;

endmodule

/* design/sosl_cell.sv */
// One list cell: holds a symbol, compares it and takes part in reordering.
module sosl_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sosl_pkg::sosl_cmp_t         cmp_i,
  input  sosl_pkg::sosl_upd_t         upd_i,
  input  logic [sosl_pkg::SYM_W-1:0]  left_sym_i,
  output logic [sosl_pkg::SYM_W-1:0]  sym_o,
  output logic                        match_o
);

  localparam logic [sosl_pkg::CNT_W-1:0] MyIdx = sosl_pkg::CNT_W'(CELL_IDX);

  logic [sosl_pkg::SYM_W-1:0] sym_q, sym_d;
  logic                       match_q, match_d;
  logic                       in_list;

  assign in_list = MyIdx < cmp_i.count;

  always_comb begin
    match_d = 1'b0;
    if (cmp_i.en) begin
      if (cmp_i.access) begin
        match_d = in_list && (sym_q == cmp_i.sym);
      end else begin
        match_d = in_list && (MyIdx == cmp_i.ridx);
      end
    end
  end

  always_comb begin
    sym_d = sym_q;
    if (upd_i.en) begin
      case (upd_i.kind)
        sosl_pkg::UPD_MTF: begin
          if (MyIdx == '0) begin
            sym_d = upd_i.sym;
          end else if (MyIdx <= upd_i.found) begin
            sym_d = left_sym_i;
          end
        end
        sosl_pkg::UPD_SWAP: begin
          if (MyIdx == upd_i.found - 1'b1) begin
            sym_d = upd_i.sym;
          end else if (MyIdx == upd_i.found) begin
            sym_d = left_sym_i;
          end
        end
        sosl_pkg::UPD_APPEND: begin
          if (MyIdx == upd_i.count) begin
            sym_d = upd_i.sym;
          end
        end
        default: sym_d = sym_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  assign sym_o   = sym_q;
  assign match_o = match_q;

endmodule

/* design/sosl_enc.sv */
// Encodes the one-hot cell match row into a position and the matching symbol.
module sosl_enc #(
  parameter int LIST_DEPTH = 256
) (
  input  logic [LIST_DEPTH-1:0]                       match_i,
  input  logic [LIST_DEPTH-1:0][sosl_pkg::SYM_W-1:0]  syms_i,
  output logic [sosl_pkg::CNT_W-1:0]                  found_o,
  output logic                                        any_o,
  output logic [sosl_pkg::SYM_W-1:0]                  sym_o
);

  always_comb begin
    found_o = '0;
    sym_o   = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      found_o = found_o | (match_i[k] ? sosl_pkg::CNT_W'(k) : '0);
      sym_o   = sym_o | (match_i[k] ? syms_i[k] : '0);
    end
  end

  assign any_o = |match_i;

endmodule
